FILE: rtl/sitoa_pkg.sv
// Package with the shared types, constants and character mapping of the integer-to-text converter.
`timescale 1ns / 1ps
`default_nettype none

package sitoa_pkg;

    localparam logic [5:0] RADIX_RESET   = 6'd10;
    localparam logic [5:0] RADIX_MIN     = 6'd2;
    localparam logic [5:0] RADIX_MAX     = 6'd36;
    localparam logic [6:0] LETTER_OFFSET = 7'd87;
    localparam logic [6:0] CHAR_ZERO     = 7'd48;
    localparam logic [6:0] CHAR_MINUS    = 7'd45;
    localparam logic [5:0] DIGIT_MAX_DEC = 6'd9;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic emit_sign;
        logic read;
        logic emit_digit;
    } sitoa_cmd_t;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic negative;
        logic count_zero;
    } sitoa_status_t;

    function automatic logic [6:0] digit_to_ascii(input logic [5:0] digit);
        logic [6:0] wide;
        wide = {1'b0, digit};
        if (digit > DIGIT_MAX_DEC)
        begin
            digit_to_ascii = wide + LETTER_OFFSET;
        end
        else
        begin
            digit_to_ascii = wide + CHAR_ZERO;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sitoa_ctrl.sv
// Controller state machine that sequences division, digit storage and character output.
`timescale 1ns / 1ps
`default_nettype none

module sitoa_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire sitoa_pkg::sitoa_status_t status,
    output logic                         busy,
    output sitoa_pkg::sitoa_cmd_t        cmd
);
    import sitoa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (status.quot_zero)
                begin
                    state_next = status.negative ? S_SIGN : S_READ;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                state_next     = status.count_zero ? S_IDLE : S_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/sitoa_dp.sv
// Datapath with the radix register, bit-serial divider, digit memory and output registers.
`timescale 1ns / 1ps
`default_nettype none

module sitoa_dp #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sitoa_pkg::sitoa_cmd_t         cmd,
    output sitoa_pkg::sitoa_status_t           status,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic                          radix_wr_en,
    input  wire logic [5:0]                    radix_wr_data,
    output logic [6:0]                         char_code,
    output logic                               last_char,
    output logic                               char_valid
);
    import sitoa_pkg::*;

    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic [5:0]             radix_reg;
    logic [5:0]             radix_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic [5:0]             rem_reg;
    logic [5:0]             rem_next;
    logic [BW-1:0]          bit_cnt_reg;
    logic [BW-1:0]          bit_cnt_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [5:0]             rd_data_reg;
    logic [6:0]             char_reg;
    logic [6:0]             char_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   valid_reg;
    logic                   valid_next;

    logic [5:0]             digit_mem [MAX_DIGITS];

    logic [VALUE_WIDTH-1:0] value_u;
    logic [6:0]             rem_shift;
    logic [6:0]             rem_diff;
    logic                   fits;
    logic                   room;
    logic [CW-1:0]          count_dec;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;

    assign value_u   = value;
    assign rem_shift = {rem_reg, mag_reg[VALUE_WIDTH-1]};
    assign fits      = (rem_shift >= {1'b0, radix_reg});
    assign rem_diff  = rem_shift - {1'b0, radix_reg};
    assign room      = (count_reg < CW'(MAX_DIGITS));
    assign count_dec = count_reg - CW'(1);
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_addr   = count_dec[AW-1:0];

    always_comb
    begin
        radix_next = radix_reg;
        if (radix_wr_en)
        begin
            if (radix_wr_data < RADIX_MIN)
            begin
                radix_next = RADIX_MIN;
            end
            else if (radix_wr_data > RADIX_MAX)
            begin
                radix_next = RADIX_MAX;
            end
            else
            begin
                radix_next = radix_wr_data;
            end
        end
    end

    always_comb
    begin
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        neg_next     = neg_reg;
        if (cmd.load)
        begin
            neg_next     = value_u[VALUE_WIDTH-1];
            mag_next     = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;
            rem_next     = '0;
            bit_cnt_next = '0;
            count_next   = '0;
        end
        if (cmd.div_step)
        begin
            rem_next     = fits ? rem_diff[5:0] : rem_shift[5:0];
            mag_next     = {mag_reg[VALUE_WIDTH-2:0], fits};
            bit_cnt_next = bit_cnt_reg + BW'(1);
        end
        if (cmd.store)
        begin
            rem_next     = '0;
            bit_cnt_next = '0;
            if (room)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.read)
        begin
            count_next = count_dec;
        end
    end

    always_comb
    begin
        valid_next = cmd.emit_sign | cmd.emit_digit;
        char_next  = cmd.emit_sign ? CHAR_MINUS : digit_to_ascii(rd_data_reg);
        last_next  = cmd.emit_digit && (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg   <= RADIX_RESET;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            neg_reg     <= 1'b0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            radix_reg   <= radix_next;
            bit_cnt_reg <= bit_cnt_next;
            count_reg   <= count_next;
            neg_reg     <= neg_next;
            valid_reg   <= valid_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && room)
        begin
            digit_mem[wr_addr] <= rem_reg;
        end
        if (cmd.read)
        begin
            rd_data_reg <= digit_mem[rd_addr];
        end
    end

    assign status.div_last   = (bit_cnt_reg == BW'(VALUE_WIDTH - 1));
    assign status.quot_zero  = (mag_reg == '0);
    assign status.negative   = neg_reg;
    assign status.count_zero = (count_reg == '0);

    assign char_code  = char_reg;
    assign last_char  = last_reg;
    assign char_valid = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/signed_int_to_ascii_radix_top.sv
// Top level of the signed integer to ASCII text converter for radix 2 to 36.
//
//  Channel   Signals                          Transfer
//  --------  -------------------------------  ----------------------------------------
//  request   start, busy, value               taken at an edge with start high, busy low
//  result    char_valid, char_code, last_char one-cycle strobe per character, no back-pressure
//  config    radix_wr_en, radix_wr_data       radix written at an edge with enable high
//
// Each digit comes from the one-bit-per-cycle restoring divider and is stored in the digit
// memory; each character then passes through the registered digit memory read.
// A negative value also gets a minus sign, emitted ahead of its digits.
// Reset clears the controller, the digit count and the output strobe, and sets radix to 10.
// Characters leave on their strobe without waiting; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_ascii_radix_top #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic                          radix_wr_en,
    input  wire logic [5:0]                    radix_wr_data,
    output logic [6:0]                         char_code,
    output logic                               last_char,
    output logic                               char_valid
);
    import sitoa_pkg::*;

    sitoa_cmd_t    cmd;
    sitoa_status_t status;

    sitoa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    sitoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .value         (value),
        .radix_wr_en   (radix_wr_en),
        .radix_wr_data (radix_wr_data),
        .char_code     (char_code),
        .last_char     (last_char),
        .char_valid    (char_valid)
    );

    // Every character on the strobe is a minus sign, a decimal digit or a lower-case letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ((char_code == CHAR_MINUS) ||
                        ((char_code >= 7'd48) && (char_code <= 7'd57)) ||
                        ((char_code >= 7'd97) && (char_code <= 7'd122))))
        else $error("character outside the digit alphabet");

    // An accepted request keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without entering conversion");

    // The block goes idle exactly as the final character of a request is shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (char_valid && last_char))
        else $error("conversion ended without a final character");

    // The last flag only ever rides on a strobed character.
    assert property (@(posedge clk) disable iff (!rst_n)
        last_char |-> char_valid)
        else $error("last flag without a character strobe");

endmodule

`default_nettype wire
